>>> hw/rtl/spd_pkg.sv
// Shared constants and codes for the slotted page directory.
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_SLOTS_DEF  = 1024;

  localparam int HEADER_BYTES = 16;
  localparam int SLOT_BYTES   = 6;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 10;
  localparam int LEN_W    = 12;
  localparam int STATUS_W = 2;
  localparam int OFFS_W   = 13;
  localparam int GAP_W    = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_DELETED  = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/spd_alu.sv
// Shared subtract/compare unit: difference plus borrow (a < b).
`timescale 1ns / 1ps
`default_nettype none
module spd_alu #(
  parameter int W = 13
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  logic [W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule
`default_nettype wire

>>> hw/rtl/spd_slot_ram.sv
// Slot table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module spd_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int EW    = 26
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/slotted_page_directory_top.sv
// Slotted page directory: sequencer, page counters and result register.
//
//  channel  signals                         word contents
//  -------  ------------------------------  ------------------------------------------
//  req      req_valid / req_ready           cmd, slot_index, tuple_bytes
//  rsp      rsp_valid / rsp_ready           status, assigned_slot, tuple_pos,
//                                           tuple_length, gap_bytes
//
// States per word, from acceptance until the result register loads: insert S_INS_SUB,
//   S_INS_FIT, S_INS_PUT (no space skips to S_DONE), S_DONE; delete/get S_LOOK, S_CHK,
//   S_DONE; clear S_DONE. Gap, offset and range arithmetic runs through one shared
//   subtract/compare unit, one operation per cycle; S_LOOK issues the registered slot-table read.
// req_ready is high only while the sequencer is idle. A new word may be taken
//   while the previous result still waits in the result register; the
//   sequencer then holds its finished result until that register frees up.
// rst (synchronous) empties the page: counters return to their start values.
//   The slot table itself is not cleared; only entries below slot_count are used.
`timescale 1ns / 1ps
`default_nettype none
module slotted_page_directory_top #(
  parameter int PAGE_BYTES = spd_pkg::PAGE_BYTES_DEF,
  parameter int MAX_SLOTS  = spd_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [spd_pkg::CMD_W-1:0]     cmd,
  input  logic [spd_pkg::IDX_W-1:0]     slot_index,
  input  logic [spd_pkg::LEN_W-1:0]     tuple_bytes,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [spd_pkg::STATUS_W-1:0]  status,
  output logic [spd_pkg::IDX_W-1:0]     assigned_slot,
  output logic [spd_pkg::OFFS_W-1:0]    tuple_pos,
  output logic [spd_pkg::LEN_W-1:0]     tuple_length,
  output logic [spd_pkg::GAP_W-1:0]     gap_bytes
);
  import spd_pkg::*;

  // Byte offsets run 0..PAGE_BYTES, slot counts 0..MAX_SLOTS.
  localparam int OFF_W = $clog2(PAGE_BYTES + 1);
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int DW0   = (OFF_W > CW) ? OFF_W : CW;
  // Datapath also covers the 12-bit length and 13-bit offset fields.
  localparam int DW    = (DW0 > OFFS_W) ? DW0 : OFFS_W;
  // Slot entry: {deleted, length, offset}
  localparam int EW    = OFF_W + LEN_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SUB,   // gap - len
    S_INS_FIT,   // (gap - len) - slot size
    S_INS_PUT,   // offset = tuple_area_start - len, write entry
    S_LOOK,      // range compare, issue table read
    S_CHK,       // check entry, mark deleted or return it
    S_DONE       // wait for the result register
  } state_t;

  state_t state;

  // page counters
  logic [OFF_W-1:0] tuple_area_start;
  logic [OFF_W-1:0] gap;
  logic [CW-1:0]    slot_count;

  // latched request
  cmd_t             cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [LEN_W-1:0] len_q;

  // scratch and pending result
  logic [DW-1:0]    tmp;
  logic             in_range;
  status_t          res_status;
  logic [IDX_W-1:0] res_slot;
  logic [OFFS_W-1:0] res_offs;
  logic [LEN_W-1:0] res_len;

  // result register
  status_t           rsp_status;
  logic [IDX_W-1:0]  rsp_slot;
  logic [OFFS_W-1:0] rsp_offs;
  logic [LEN_W-1:0]  rsp_len;
  logic [GAP_W-1:0]  rsp_gap;

  // shared unit
  logic [DW-1:0] alu_a;
  logic [DW-1:0] alu_b;
  logic [DW-1:0] alu_diff;
  logic          alu_borrow;

  // table ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [DW-1:0]    idx_ext;
  logic             count_full;
  logic             rsp_free;
  logic             ent_del;
  logic [LEN_W-1:0] ent_len;
  logic [OFF_W-1:0] ent_off;

  assign idx_ext    = DW'(idx_q);
  assign count_full = (slot_count == CW'(MAX_SLOTS));
  assign rsp_free   = !rsp_valid || rsp_ready;
  assign ent_off    = ram_rdata[OFF_W-1:0];
  assign ent_len    = ram_rdata[OFF_W +: LEN_W];
  assign ent_del    = ram_rdata[EW-1];

  // operand select for the shared unit
  always_comb begin
    alu_a = DW'(gap);
    alu_b = DW'(len_q);
    case (state)
      S_INS_FIT: begin
        alu_a = tmp;
        alu_b = DW'(SLOT_BYTES);
      end
      S_INS_PUT: begin
        alu_a = DW'(tuple_area_start);
        alu_b = DW'(len_q);
      end
      S_LOOK: begin
        alu_a = idx_ext;
        alu_b = DW'(slot_count);
      end
      default: begin
        alu_a = DW'(gap);
        alu_b = DW'(len_q);
      end
    endcase
  end

  spd_alu #(.W(DW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // table write: new entry on insert, deleted mark on delete
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_count[AW-1:0];
    ram_wdata = {1'b0, len_q, alu_diff[OFF_W-1:0]};
    if (state == S_INS_PUT) begin
      ram_we = 1'b1;
    end else if (state == S_CHK && cmd_q == CMD_DELETE && in_range && !ent_del) begin
      ram_we    = 1'b1;
      ram_waddr = idx_ext[AW-1:0];
      ram_wdata = {1'b1, ent_len, ent_off};
    end
  end

  assign ram_raddr = idx_ext[AW-1:0];

  spd_slot_ram #(.DEPTH(MAX_SLOTS), .AW(AW), .EW(EW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      tuple_area_start <= OFF_W'(PAGE_BYTES);
      gap              <= OFF_W'(PAGE_BYTES - HEADER_BYTES);
      slot_count       <= '0;
      rsp_valid        <= 1'b0;
    end else begin
      // in S_DONE the result register reloads instead
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q      <= cmd_t'(cmd);
            idx_q      <= slot_index;
            len_q      <= tuple_bytes;
            res_status <= ST_OK;
            res_slot   <= '0;
            res_offs   <= '0;
            res_len    <= '0;
            unique case (cmd_t'(cmd)) inside
              CMD_INSERT: state <= S_INS_SUB;
              CMD_DELETE, CMD_GET: state <= S_LOOK;
              CMD_CLEAR: begin
                tuple_area_start <= OFF_W'(PAGE_BYTES);
                gap              <= OFF_W'(PAGE_BYTES - HEADER_BYTES);
                slot_count       <= '0;
                state            <= S_DONE;
              end
            endcase
          end
        end
        S_INS_SUB: begin
          tmp <= alu_diff;
          if (alu_borrow || count_full) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            state <= S_INS_FIT;
          end
        end
        S_INS_FIT: begin
          tmp <= alu_diff;
          if (alu_borrow) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          tuple_area_start <= alu_diff[OFF_W-1:0];
          gap              <= tmp[OFF_W-1:0];
          slot_count       <= slot_count + 1'b1;
          res_slot         <= IDX_W'(slot_count);
          res_offs         <= OFFS_W'(alu_diff);
          res_len          <= len_q;
          state            <= S_DONE;
        end
        S_LOOK: begin
          in_range <= alu_borrow;  // idx < slot_count
          state    <= S_CHK;
        end
        S_CHK: begin
          if (!in_range) begin
            res_status <= ST_RANGE;
          end else if (ent_del) begin
            res_status <= ST_DELETED;
          end else if (cmd_q == CMD_GET) begin
            res_offs <= OFFS_W'(ent_off);
            res_len  <= ent_len;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_slot   <= res_slot;
            rsp_offs   <= res_offs;
            rsp_len    <= res_len;
            rsp_gap    <= GAP_W'(gap);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready     = (state == S_IDLE);
  assign status        = rsp_status;
  assign assigned_slot = rsp_slot;
  assign tuple_pos     = rsp_offs;
  assign tuple_length  = rsp_len;
  assign gap_bytes     = rsp_gap;

endmodule
`default_nettype wire

>>> hw/rtl/spd_checker.sv
// Port-level checks for the slotted page directory, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module spd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic [spd_pkg::STATUS_W-1:0]  status,
  input  logic [spd_pkg::IDX_W-1:0]     assigned_slot,
  input  logic [spd_pkg::OFFS_W-1:0]    tuple_pos,
  input  logic [spd_pkg::LEN_W-1:0]     tuple_length,
  input  logic [spd_pkg::GAP_W-1:0]     gap_bytes
);
  import spd_pkg::*;

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(assigned_slot)
      && $stable(tuple_pos) && $stable(tuple_length) && $stable(gap_bytes))
    else $error("result word changed while stalled");

  // failed commands carry no slot, offset or length
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> assigned_slot == '0 && tuple_pos == '0
      && tuple_length == '0)
    else $error("failed command returned nonzero fields");

  // req_ready drops after every accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after accepting a word");

  // a result only appears after an accepted word
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result without a command in progress");

endmodule

bind slotted_page_directory_top spd_checker u_spd_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_ready     (req_ready),
  .rsp_valid     (rsp_valid),
  .rsp_ready     (rsp_ready),
  .status        (status),
  .assigned_slot (assigned_slot),
  .tuple_pos     (tuple_pos),
  .tuple_length  (tuple_length),
  .gap_bytes     (gap_bytes)
);
`default_nettype wire
